@@ hw/rtl/colored_noise_heun_step_assert.svh @@
// ----------------------------------------------------------------------------
// Colored noise Heun step assertion macros
// Shorthand for the clocked properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef COLORED_NOISE_HEUN_STEP_ASSERT_SVH
`define COLORED_NOISE_HEUN_STEP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CNHS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("colored_noise_heun_step assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CNHS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("colored_noise_heun_step assertion failed");

`endif

@@ hw/rtl/cnhs_pkg.sv @@
// ----------------------------------------------------------------------------
// Colored noise Heun step package
// Shared types, constants and the micro-program of the arithmetic sequencer.
// ----------------------------------------------------------------------------
package cnhs_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DIV_BITS  = 32 + FRAC_BITS;
    localparam int DIV_STEPS = DIV_BITS / 2;

    localparam logic signed [31:0] Q_ONE         = 32'sd16777216;
    localparam logic signed [31:0] Q_NINE_TENTHS = 32'sd15099494;
    localparam logic signed [31:0] Q_ONE_TENTH   = 32'sd1677722;
    localparam logic [30:0]        CUT_OFF       = 31'h7FFF_FFFF;
    localparam logic [4:0]         PHASE_TWO_AFTER   = 5'd10;
    localparam logic [4:0]         PHASE_THREE_AFTER = 5'd20;

    typedef enum logic [2:0] {
        CFG_CORR_TIME      = 3'd0,
        CFG_STAT_SHAPE     = 3'd1,
        CFG_TIME_STEP      = 3'd2,
        CFG_SQRT_TIME_STEP = 3'd3,
        CFG_OU_DECAY       = 3'd4,
        CFG_OU_GAIN        = 3'd5,
        CFG_BOUND_CUT      = 3'd6,
        CFG_START_VALUE    = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_DIV  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_ADD3 = 3'd4
    } op_t;

    typedef enum logic [4:0] {
        SRC_ETA         = 5'd0,
        SRC_X           = 5'd1,
        SRC_T           = 5'd2,
        SRC_P0          = 5'd3,
        SRC_K           = 5'd4,
        SRC_L           = 5'd5,
        SRC_TAU         = 5'd6,
        SRC_QM1         = 5'd7,
        SRC_H           = 5'd8,
        SRC_HALF_H      = 5'd9,
        SRC_SQRT_H      = 5'd10,
        SRC_G           = 5'd11,
        SRC_G2          = 5'd12,
        SRC_DECAY       = 5'd13,
        SRC_GAIN        = 5'd14,
        SRC_CUT         = 5'd15,
        SRC_U           = 5'd16,
        SRC_ONE         = 5'd17,
        SRC_NINE_TENTHS = 5'd18,
        SRC_ONE_TENTH   = 5'd19
    } src_t;

    typedef enum logic [2:0] {
        DST_X  = 3'd0,
        DST_T  = 3'd1,
        DST_P0 = 3'd2,
        DST_K  = 3'd3,
        DST_L  = 3'd4
    } dst_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        dst_t dst;
        logic last;
    } uop_t;

    localparam logic [4:0] PC_HEUN_LAST   = 5'd19;
    localparam logic [4:0] PC_FORCE_FIRST = 5'd20;
    localparam logic [4:0] PC_FORCE_LAST  = 5'd22;
    localparam logic [4:0] PC_OU_FIRST    = 5'd23;
    localparam logic [4:0] PC_OU_LAST     = 5'd26;

    // Heun attempt, then the forced value, then the fallback rewrite.
    // ADD3 adds the l term as a third operand without intermediate saturation.
    function automatic uop_t uop_at(input logic [4:0] pc);
        uop_t u;
        u = '{OP_ADD, SRC_ONE, SRC_T, DST_T, 1'b1};
        unique case (pc)
            5'd0:  u = '{OP_MUL,  SRC_X,      SRC_X,       DST_T,  1'b0};
            5'd1:  u = '{OP_MUL,  SRC_T,      SRC_TAU,     DST_T,  1'b0};
            5'd2:  u = '{OP_MUL,  SRC_T,      SRC_QM1,     DST_T,  1'b0};
            5'd3:  u = '{OP_ADD,  SRC_ONE,    SRC_T,       DST_T,  1'b0};
            5'd4:  u = '{OP_DIV,  SRC_X,      SRC_T,       DST_T,  1'b0};
            5'd5:  u = '{OP_DIV,  SRC_T,      SRC_TAU,     DST_P0, 1'b0};
            5'd6:  u = '{OP_MUL,  SRC_H,      SRC_P0,      DST_K,  1'b0};
            5'd7:  u = '{OP_MUL,  SRC_SQRT_H, SRC_G,       DST_L,  1'b0};
            5'd8:  u = '{OP_DIV,  SRC_L,      SRC_TAU,     DST_L,  1'b0};
            5'd9:  u = '{OP_ADD3, SRC_ETA,    SRC_K,       DST_X,  1'b0};
            5'd10: u = '{OP_MUL,  SRC_X,      SRC_X,       DST_T,  1'b0};
            5'd11: u = '{OP_MUL,  SRC_T,      SRC_TAU,     DST_T,  1'b0};
            5'd12: u = '{OP_MUL,  SRC_T,      SRC_QM1,     DST_T,  1'b0};
            5'd13: u = '{OP_ADD,  SRC_ONE,    SRC_T,       DST_T,  1'b0};
            5'd14: u = '{OP_DIV,  SRC_X,      SRC_T,       DST_T,  1'b0};
            5'd15: u = '{OP_DIV,  SRC_T,      SRC_TAU,     DST_T,  1'b0};
            5'd16: u = '{OP_ADD,  SRC_P0,     SRC_T,       DST_T,  1'b0};
            5'd17: u = '{OP_MUL,  SRC_HALF_H, SRC_T,       DST_T,  1'b0};
            5'd18: u = '{OP_SUB,  SRC_L,      SRC_T,       DST_T,  1'b0};
            5'd19: u = '{OP_ADD,  SRC_ETA,    SRC_T,       DST_X,  1'b1};
            5'd20: u = '{OP_MUL,  SRC_ONE_TENTH, SRC_U,    DST_T,  1'b0};
            5'd21: u = '{OP_ADD,  SRC_NINE_TENTHS, SRC_T,  DST_T,  1'b0};
            5'd22: u = '{OP_MUL,  SRC_CUT,    SRC_T,       DST_T,  1'b1};
            5'd23: u = '{OP_MUL,  SRC_ETA,    SRC_DECAY,   DST_T,  1'b0};
            5'd24: u = '{OP_MUL,  SRC_GAIN,   SRC_G2,      DST_K,  1'b0};
            5'd25: u = '{OP_ADD,  SRC_T,      SRC_K,       DST_T,  1'b0};
            5'd26: u = '{OP_MUL,  SRC_CUT,    SRC_T,       DST_T,  1'b1};
            default: u = '{OP_ADD, SRC_ONE, SRC_T, DST_T, 1'b1};
        endcase
        return u;
    endfunction

endpackage

@@ hw/rtl/cnhs_div.sv @@
// ----------------------------------------------------------------------------
// Colored noise Heun step divider
// Signed Q8.24 quotient (a * 2^24) / b, truncated toward zero and saturated,
// two quotient bits per cycle.
// ----------------------------------------------------------------------------
module cnhs_div
    import cnhs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                run_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                neg_reg;
    logic [31:0]         rem_reg;
    logic [DIV_BITS-1:0] quo_reg;
    logic [31:0]         dvs_reg;

    logic [31:0] dividend_mag;
    logic [31:0] divisor_mag;
    logic [32:0] step1;
    logic [32:0] step2;
    logic [DIV_BITS-1:0] quo_next;

    // Returns {quotient bit, new remainder}.
    function automatic logic [32:0] div_step(input logic [31:0] rem,
                                             input logic        bit_in,
                                             input logic [31:0] dvs);
        logic [33:0] diff;
        logic [32:0] shifted;
        shifted = {rem, bit_in};
        diff = {1'b0, shifted} - {2'b00, dvs};
        return diff[33] ? {1'b0, shifted[31:0]} : {1'b1, diff[31:0]};
    endfunction

    always_comb
    begin
        dividend_mag = dividend[31] ? 32'(-dividend) : dividend;
        divisor_mag  = divisor[31] ? 32'(-divisor) : divisor;
        step1 = div_step(rem_reg, quo_reg[DIV_BITS-1], dvs_reg);
        step2 = div_step(step1[31:0], quo_reg[DIV_BITS-2], dvs_reg);
        quo_next = {quo_reg[DIV_BITS-3:0], step1[32], step2[32]};
    end

    // A zero divisor makes every trial succeed, so the magnitude overflows and
    // saturates toward the sign of the dividend, as required.
    always_comb
    begin
        if (!neg_reg) begin
            if (quo_reg > DIV_BITS'(32'h7FFF_FFFF))
                quotient = 32'sh7FFF_FFFF;
            else
                quotient = quo_reg[31:0];
        end
        else begin
            if (quo_reg > DIV_BITS'(32'h8000_0000))
                quotient = 32'sh8000_0000;
            else
                quotient = 32'(32'd0 - quo_reg[31:0]);
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= !start && run_reg && (cnt_reg == CNT_W'(DIV_STEPS - 1));
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            neg_reg <= dividend[31] ^ divisor[31];
            rem_reg <= '0;
            quo_reg <= {dividend_mag, FRAC_BITS'(0)};
            dvs_reg <= divisor_mag;
        end
        else if (run_reg) begin
            rem_reg <= step2[31:0];
            quo_reg <= quo_next;
        end
    end

endmodule

@@ hw/rtl/colored_noise_heun_step.sv @@
// ----------------------------------------------------------------------------
// Colored noise Heun step
// An attempt either emits an accepted sample, emits a forced value, or ends
// with no result, possibly after the fallback rewrite. The Heun attempt runs
// five divisions on the shared divider. Input is stalled until the attempt
// finishes and while a result waits. Reset restores register defaults and
// clears the working value and count.
// ----------------------------------------------------------------------------
module colored_noise_heun_step
    import cnhs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] gauss_drive,
    input  logic signed [31:0] gauss_fallback,
    input  logic [23:0]        uniform_draw,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] noise_value,
    output logic               forced_reset
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ISSUE  = 6'b000010,
        S_MUL    = 6'b000100,
        S_DIV    = 6'b001000,
        S_DECIDE = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
    localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

    state_t state_reg;
    logic [4:0] pc_reg;

    logic [30:0]        corr_time_reg;
    logic signed [31:0] stat_shape_reg;
    logic [30:0]        time_step_reg;
    logic [30:0]        sqrt_time_step_reg;
    logic [24:0]        ou_decay_reg;
    logic [30:0]        ou_gain_reg;
    logic [30:0]        bound_cut_reg;

    logic signed [31:0] working_reg;
    logic [4:0]         count_reg;

    logic signed [31:0] x_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] p0_reg;
    logic signed [31:0] k_reg;
    logic signed [31:0] l_reg;
    logic signed [31:0] g_reg;
    logic signed [31:0] g2_reg;
    logic [23:0]        u_reg;
    logic signed [63:0] prod_reg;

    logic               out_valid_reg;
    logic signed [31:0] noise_value_reg;
    logic               forced_reset_reg;

    uop_t               cur_uop;
    logic signed [31:0] a_val;
    logic signed [31:0] b_val;
    logic signed [31:0] qm1;
    logic signed [31:0] add_res;
    logic signed [31:0] mul_res;
    logic signed [31:0] div_q;
    logic               div_done;
    logic               div_start;
    logic               in_fire;
    logic               out_free;
    logic [32:0]        cand_mag;
    logic               cand_ok;
    logic [4:0]         count_next;
    logic signed [31:0] forced_val;

    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        if (v > SAT_HI)
            return 32'sh7FFF_FFFF;
        else if (v < SAT_LO)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] operand(input src_t src);
        logic signed [31:0] v;
        v = '0;
        unique case (src)
            SRC_ETA:         v = working_reg;
            SRC_X:           v = x_reg;
            SRC_T:           v = t_reg;
            SRC_P0:          v = p0_reg;
            SRC_K:           v = k_reg;
            SRC_L:           v = l_reg;
            SRC_TAU:         v = {1'b0, corr_time_reg};
            SRC_QM1:         v = qm1;
            SRC_H:           v = {1'b0, time_step_reg};
            SRC_HALF_H:      v = {2'b00, time_step_reg[30:1]};
            SRC_SQRT_H:      v = {1'b0, sqrt_time_step_reg};
            SRC_G:           v = g_reg;
            SRC_G2:          v = g2_reg;
            SRC_DECAY:       v = {7'd0, ou_decay_reg};
            SRC_GAIN:        v = {1'b0, ou_gain_reg};
            SRC_CUT:         v = {1'b0, bound_cut_reg};
            SRC_U:           v = {8'd0, u_reg};
            SRC_ONE:         v = Q_ONE;
            SRC_NINE_TENTHS: v = Q_NINE_TENTHS;
            SRC_ONE_TENTH:   v = Q_ONE_TENTH;
            default:         v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        logic signed [33:0] a34;
        logic signed [33:0] b34;
        logic signed [33:0] c34;
        logic signed [33:0] sum34;
        logic signed [33:0] qm1_34;

        qm1_34 = {{2{stat_shape_reg[31]}}, stat_shape_reg} - 34'sd16777216;
        qm1 = sat40({{6{qm1_34[33]}}, qm1_34});

        cur_uop = uop_at(pc_reg);
        a_val = operand(cur_uop.a);
        b_val = operand(cur_uop.b);

        a34 = {{2{a_val[31]}}, a_val};
        b34 = {{2{b_val[31]}}, b_val};
        c34 = (cur_uop.op == OP_ADD3) ? {{2{l_reg[31]}}, l_reg} : 34'sd0;
        if (cur_uop.op == OP_SUB)
            sum34 = a34 - b34;
        else
            sum34 = a34 + b34 + c34;
        add_res = sat40({{6{sum34[33]}}, sum34});

        // Arithmetic shift of the product is the floor of p / 2^24.
        mul_res = sat40(prod_reg[63:24]);
    end

    always_comb
    begin
        cand_mag = x_reg[31] ? 33'(-{x_reg[31], x_reg}) : {1'b0, x_reg};
        cand_ok  = (bound_cut_reg == CUT_OFF) || (cand_mag <= {2'b00, bound_cut_reg});
        count_next = count_reg + 1'b1;
        forced_val = working_reg[31] ? 32'(-t_reg) : t_reg;
    end

    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign div_start = (state_reg == S_ISSUE) && (cur_uop.op == OP_DIV);
    assign in_stall  = (state_reg != S_IDLE);

    assign out_valid    = out_valid_reg;
    assign noise_value  = noise_value_reg;
    assign forced_reset = forced_reset_reg;

    cnhs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_val),
        .divisor  (b_val),
        .done     (div_done),
        .quotient (div_q)
    );

    // Control, configuration and noise state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg          <= S_IDLE;
            pc_reg             <= '0;
            corr_time_reg      <= 31'd16777216;
            stat_shape_reg     <= 32'sd16777216;
            time_step_reg      <= 31'd167772;
            sqrt_time_step_reg <= 31'd1677722;
            ou_decay_reg       <= 25'd16610218;
            ou_gain_reg        <= 31'd1669371;
            bound_cut_reg      <= CUT_OFF;
            working_reg        <= '0;
            count_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end
        else begin
            if (state_reg == S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_CORR_TIME:      corr_time_reg      <= cfg_data[30:0];
                    CFG_STAT_SHAPE:     stat_shape_reg     <= cfg_data;
                    CFG_TIME_STEP:      time_step_reg      <= cfg_data[30:0];
                    CFG_SQRT_TIME_STEP: sqrt_time_step_reg <= cfg_data[30:0];
                    CFG_OU_DECAY:       ou_decay_reg       <= cfg_data[24:0];
                    CFG_OU_GAIN:        ou_gain_reg        <= cfg_data[30:0];
                    CFG_BOUND_CUT:      bound_cut_reg      <= cfg_data[30:0];
                    CFG_START_VALUE:
                    begin
                        working_reg <= cfg_data;
                        count_reg   <= '0;
                    end
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire) begin
                        pc_reg    <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    unique case (cur_uop.op) inside
                        OP_MUL: state_reg <= S_MUL;
                        OP_DIV: state_reg <= S_DIV;
                        OP_ADD, OP_SUB, OP_ADD3:
                        begin
                            if (cur_uop.last)
                                state_reg <= S_DECIDE;
                            else
                                pc_reg <= pc_reg + 1'b1;
                        end
                        default: state_reg <= S_ISSUE;
                    endcase
                end
                S_MUL:
                begin
                    if (cur_uop.last) begin
                        state_reg <= S_DECIDE;
                    end
                    else begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= S_ISSUE;
                    end
                end
                S_DIV:
                begin
                    if (div_done) begin
                        if (cur_uop.last) begin
                            state_reg <= S_DECIDE;
                        end
                        else begin
                            pc_reg    <= pc_reg + 1'b1;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_DECIDE:
                begin
                    if (pc_reg == PC_HEUN_LAST) begin
                        if (cand_ok) begin
                            working_reg <= x_reg;
                            count_reg   <= '0;
                            state_reg   <= S_EMIT;
                        end
                        else begin
                            count_reg <= count_next;
                            if (count_next > PHASE_THREE_AFTER) begin
                                pc_reg    <= PC_FORCE_FIRST;
                                state_reg <= S_ISSUE;
                            end
                            else if (count_next > PHASE_TWO_AFTER) begin
                                pc_reg    <= PC_OU_FIRST;
                                state_reg <= S_ISSUE;
                            end
                            else begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    else if (pc_reg == PC_FORCE_LAST) begin
                        working_reg <= forced_val;
                        count_reg   <= '0;
                        state_reg   <= S_EMIT;
                    end
                    else begin
                        working_reg <= t_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Operand latches, temporaries and the result register.
    always_ff @(posedge clk)
    begin
        logic               wb_en;
        logic signed [31:0] wb_val;

        wb_en  = 1'b0;
        wb_val = add_res;
        if (state_reg == S_ISSUE && cur_uop.op != OP_MUL && cur_uop.op != OP_DIV) begin
            wb_en = 1'b1;
        end
        else if (state_reg == S_MUL) begin
            wb_en  = 1'b1;
            wb_val = mul_res;
        end
        else if (state_reg == S_DIV && div_done) begin
            wb_en  = 1'b1;
            wb_val = div_q;
        end

        if (state_reg == S_IDLE && in_fire) begin
            g_reg  <= gauss_drive;
            g2_reg <= gauss_fallback;
            u_reg  <= uniform_draw;
            x_reg  <= working_reg;
        end

        if (state_reg == S_ISSUE && cur_uop.op == OP_MUL)
            prod_reg <= a_val * b_val;

        if (wb_en) begin
            unique case (cur_uop.dst)
                DST_X:   x_reg  <= wb_val;
                DST_T:   t_reg  <= wb_val;
                DST_P0:  p0_reg <= wb_val;
                DST_K:   k_reg  <= wb_val;
                DST_L:   l_reg  <= wb_val;
                default: t_reg  <= wb_val;
            endcase
        end

        if (state_reg == S_DECIDE && pc_reg == PC_FORCE_LAST)
            x_reg <= forced_val;

        if (state_reg == S_EMIT && out_free) begin
            noise_value_reg  <= x_reg;
            forced_reset_reg <= (pc_reg == PC_FORCE_LAST);
        end
    end

endmodule

@@ hw/rtl/cnhs_checker.sv @@
// ----------------------------------------------------------------------------
// Colored noise Heun step checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "colored_noise_heun_step_assert.svh"

module cnhs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] noise_value,
    input logic               forced_reset
);

    // An accepted transaction keeps the block busy in the cycle after it.
    `CNHS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // A stalled result keeps its value.
    `CNHS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(noise_value) && $stable(forced_reset))

    // A new result only appears at the end of an attempt.
    `CNHS_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(in_stall))

    // No result can come out in the cycle right after an accept.
    `CNHS_ASSERT_NXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind colored_noise_heun_step cnhs_checker u_cnhs_checker (.*);

@@ tb/sv/tb_colored_noise_heun_step.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Colored noise Heun step testbench
// Drives Heun attempts through the block under several register settings and
// compares every emitted sample against a fixed-point predictor in a scoreboard.
// ----------------------------------------------------------------------------
module tb_colored_noise_heun_step;
    import cnhs_pkg::*;

    localparam longint ONE_Q      = 64'sd16777216;
    localparam longint MAX_S32    = 64'sd2147483647;
    localparam longint MIN_S32    = -64'sd2147483648;
    localparam int     SETTLE_CYC = 250;
    localparam int     WDOG_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] noise;
        logic               forced;
    } sample_t;

    class noise_scoreboard;
        longint  tau, shape, step_h, sqrt_h, decay, gain, cut;
        longint  cur_noise, work_noise;
        int      tries;
        sample_t expected_q[$];
        int      errors;

        function new();
            tau        = 16777216;
            shape      = 16777216;
            step_h     = 167772;
            sqrt_h     = 1677722;
            decay      = 16610218;
            gain       = 1669371;
            cut        = 2147483647;
            cur_noise  = 0;
            work_noise = 0;
            tries      = 0;
            errors     = 0;
        endfunction

        function longint sat(longint v);
            if (v > MAX_S32) return MAX_S32;
            if (v < MIN_S32) return MIN_S32;
            return v;
        endfunction

        // Product rounded toward minus infinity.
        function longint fmul(longint a, longint b);
            longint p;
            p = a * b;
            return sat(p >>> 24);
        endfunction

        function longint fdiv(longint a, longint b);
            if (b == 0) return (a >= 0) ? MAX_S32 : MIN_S32;
            return sat((a * ONE_Q) / b);
        endfunction

        function longint drift(longint x);
            longint t, den;
            t   = fmul(fmul(x, x), tau);
            t   = fmul(t, sat(shape - ONE_Q));
            den = sat(ONE_Q + t);
            return fdiv(fdiv(x, den), tau);
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] data);
            case (idx)
                CFG_CORR_TIME:      tau    = longint'(data[30:0]);
                CFG_STAT_SHAPE:     shape  = longint'($signed(data));
                CFG_TIME_STEP:      step_h = longint'(data[30:0]);
                CFG_SQRT_TIME_STEP: sqrt_h = longint'(data[30:0]);
                CFG_OU_DECAY:       decay  = longint'(data[24:0]);
                CFG_OU_GAIN:        gain   = longint'(data[30:0]);
                CFG_BOUND_CUT:      cut    = longint'(data[30:0]);
                CFG_START_VALUE:
                begin
                    cur_noise  = longint'($signed(data));
                    work_noise = cur_noise;
                    tries      = 0;
                end
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [31:0] g, logic signed [31:0] g2,
                                 logic [23:0] u);
            longint  eta, p0, k, l, p1, d, cand, mag, m, ou;
            sample_t s;
            eta  = work_noise;
            p0   = drift(eta);
            k    = fmul(step_h, p0);
            l    = fdiv(fmul(sqrt_h, longint'(g)), tau);
            p1   = drift(sat(eta + k + l));
            d    = sat(l - fmul(step_h >>> 1, sat(p0 + p1)));
            cand = sat(eta + d);
            mag  = (cand < 0) ? -cand : cand;
            if (cut == MAX_S32 || mag <= cut)
            begin
                cur_noise  = cand;
                work_noise = cand;
                tries      = 0;
                s.noise    = cand[31:0];
                s.forced   = 1'b0;
                expected_q.push_back(s);
                return;
            end
            tries++;
            if (tries > 20)
            begin
                m = fmul(cut, 64'sd15099494 + fmul(64'sd1677722, longint'(u)));
                // A working value of zero takes the positive sign.
                cur_noise  = (eta >= 0) ? m : -m;
                work_noise = cur_noise;
                tries      = 0;
                s.noise    = cur_noise[31:0];
                s.forced   = 1'b1;
                expected_q.push_back(s);
            end
            else if (tries > 10)
            begin
                ou         = sat(fmul(eta, decay) + fmul(gain, longint'(g2)));
                work_noise = fmul(cut, ou);
            end
        endfunction

        function void check_result(logic signed [31:0] noise, logic forced);
            sample_t s;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected transaction: noise %0d forced %0b", noise, forced);
                return;
            end
            s = expected_q.pop_front();
            if (s.noise !== noise || s.forced !== forced)
            begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: expected noise %0d forced %0b, got %0d forced %0b",
                             s.noise, s.forced, noise, forced);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] gauss_drive;
    logic signed [31:0] gauss_fallback;
    logic [23:0]        uniform_draw;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] noise_value;
    logic               forced_reset;

    noise_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int quiet_cycles;

    colored_noise_heun_step DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .gauss_drive    (gauss_drive),
        .gauss_fallback (gauss_fallback),
        .uniform_draw   (uniform_draw),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .noise_value    (noise_value),
        .forced_reset   (forced_reset)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_setting(logic [31:0] tau, logic [31:0] q, logic [31:0] h,
                                logic [31:0] sqh, logic [31:0] dec, logic [31:0] gn,
                                logic [31:0] ct, logic [31:0] start);
        write_reg(CFG_CORR_TIME, tau);
        write_reg(CFG_STAT_SHAPE, q);
        write_reg(CFG_TIME_STEP, h);
        write_reg(CFG_SQRT_TIME_STEP, sqh);
        write_reg(CFG_OU_DECAY, dec);
        write_reg(CFG_OU_GAIN, gn);
        write_reg(CFG_BOUND_CUT, ct);
        write_reg(CFG_START_VALUE, start);
    endtask

    task automatic send_attempt(logic [31:0] g, logic [31:0] g2, logic [23:0] u);
        in_valid       <= 1'b1;
        gauss_drive    <= g;
        gauss_fallback <= g2;
        uniform_draw   <= u;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(g, g2, u);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_random_attempt();
        logic [31:0] g, g2;
        g  = ($urandom_range(3) == 0) ? $urandom
                                      : 32'($urandom_range(0, 8 * 16777216)) - 32'd67108864;
        g2 = ($urandom_range(3) == 0) ? $urandom
                                      : 32'($urandom_range(0, 8 * 16777216)) - 32'd67108864;
        send_attempt(g, g2, 24'($urandom_range(0, 24'hFF_FFFF)));
    endtask

    // Items that are rejected leave no result, so allow the block to finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_cut();
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return $urandom_range(1, 2 * 16777216);
            2: return $urandom_range(1, 1 << 20);
            default: return $urandom_range(1, 32'h7FFF_FFFE);
        endcase
    endfunction

    // Receiver side: random stall with one long hold-off.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(noise_value, forced_reset);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        gauss_drive    = '0;
        gauss_fallback = '0;
        uniform_draw   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults after reset, bound check disabled, extreme draws.
        send_attempt(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
        send_attempt(32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0000);
        send_attempt(32'h0000_0000, 32'hFFFF_FFFF, 24'h80_0000);
        wait_idle();

        // Cut of one with a silent fallback: the working value collapses to
        // zero, so the forced value must come out positive.
        load_setting(32'd16777216, 32'd16777216, 32'd167772, 32'd1677722,
                     32'd0, 32'd0, 32'd1, 32'd0);
        for (int i = 0; i < 21; i++)
            send_attempt(32'h7FFF_FFFF, $urandom, 24'(i * 799_999));
        wait_idle();

        // Zero denominator in the drift term.
        load_setting(32'd16777216, 32'd0, 32'd167772, 32'd1677722,
                     32'd16777216, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd16777216);
        send_attempt(32'd0, 32'd0, 24'd0);
        wait_idle();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            case (ph)
                0: load_setting(32'd16777216, 32'd16777216, 32'd167772, 32'd1677722,
                                32'd16610218, 32'd1669371, 32'h7FFF_FFFF, 32'd0);
                1: load_setting(32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'd0, 32'd0, 32'd1, 32'h7FFF_FFFF);
                2: load_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1,
                                32'd16777216, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000);
                3: load_setting(32'd16777216, 32'd25165824, 32'd167772, 32'd1677722,
                                32'd16610218, 32'd1669371, 32'd838861, 32'd0);
                default: load_setting($urandom_range(1, 32'h7FFF_FFFF), $urandom,
                                      $urandom_range(1, 32'h7FFF_FFFF),
                                      $urandom_range(1, 32'h7FFF_FFFF),
                                      $urandom_range(0, 16777216),
                                      $urandom_range(0, 32'h7FFF_FFFF),
                                      pick_cut(), $urandom);
            endcase
            if (ph == 2)
                hold_cycles = 800;
            for (int i = 0; i < 152; i++)
                send_random_attempt();
            wait_idle();
        end

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/cnhs_pkg.sv
hw/rtl/cnhs_div.sv
hw/rtl/colored_noise_heun_step.sv
hw/rtl/cnhs_checker.sv
tb/sv/tb_colored_noise_heun_step.sv
